@@ sv/tawc_pkg.sv @@
package tawc_pkg;

	localparam int STAT_W         = 32;
	localparam int POS_W          = 6;
	localparam int GE_W           = 7;
	localparam int MAX_ITEMS_DEF  = 64;
	localparam int VALUE_BITS_DEF = 32;

	// one loaded set waiting for the back end
	typedef struct packed {
		logic            bank;
		logic [GE_W-1:0] count;
		logic            ovf;
	} job_t;

endpackage

@@ sv/tawc_ram.sv @@
module tawc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/tawc_front.sv @@
module tawc_front #(
	parameter int MAX_ITEMS  = tawc_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = tawc_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tawc_pkg::STAT_W-1:0] stat_value,
	input  logic                              is_final,
	input  logic                              job_full,
	output logic                              job_push,
	output tawc_pkg::job_t                    job_data,
	output logic                              ram_we,
	output logic [$clog2(MAX_ITEMS):0]        ram_waddr,
	output logic [VALUE_BITS-1:0]             ram_wdata
);

	import tawc_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int EXT_W = (VALUE_BITS > STAT_W) ? VALUE_BITS : STAT_W;

	logic [CNT_W-1:0]        fill_q;
	logic                    ovf_q;
	logic                    bank_q;
	logic                    xfer;
	logic                    full;
	logic [CNT_W-1:0]        fill_inc;
	logic signed [EXT_W-1:0] ext_val;

	assign in_ready = !job_full;
	assign xfer     = in_valid && in_ready;
	assign full     = (fill_q == CNT_W'(MAX_ITEMS));
	assign fill_inc = fill_q + CNT_W'(1);

	// sign extend then keep the low bits
	assign ext_val   = EXT_W'(stat_value);
	assign ram_wdata = ext_val[VALUE_BITS-1:0];
	assign ram_we    = xfer && !full;
	assign ram_waddr = {bank_q, fill_q[IDX_W-1:0]};

	assign job_push       = xfer && is_final;
	assign job_data.bank  = bank_q;
	assign job_data.count = full ? GE_W'(fill_q) : GE_W'(fill_inc);
	assign job_data.ovf   = ovf_q || full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
		end else if (xfer) begin
			if (is_final) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				bank_q <= !bank_q;
			end else if (full) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_inc;
			end
		end
	end

endmodule

@@ sv/tawc_job_fifo.sv @@
module tawc_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tawc_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output tawc_pkg::job_t head
);

	import tawc_pkg::*;

	job_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ sv/tawc_back.sv @@
module tawc_back #(
	parameter int MAX_ITEMS  = tawc_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = tawc_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  tawc_pkg::job_t                   head,
	output logic                             pop,
	output logic [$clog2(MAX_ITEMS):0]       ram_raddr,
	input  logic [VALUE_BITS-1:0]            ram_rdata,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tawc_pkg::POS_W-1:0]       item_position,
	output logic [tawc_pkg::GE_W-1:0]        ge_count,
	output logic                             overflowed,
	output logic                             final_result
);

	import tawc_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_LATCH = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       i_q;
	logic [CNT_W-1:0]       j_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_BITS-1:0]  pivot_q;
	logic [CNT_W-1:0]       n_cnt;
	logic [IDX_W-1:0]       rd_idx;
	logic                   is_last;
	logic                   load;
	logic                   ge;

	assign n_cnt   = head.count[CNT_W-1:0];
	assign is_last = ((CNT_W'(i_q) + CNT_W'(1)) == n_cnt);
	assign load    = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign pop     = load && is_last;
	assign ge      = $signed(ram_rdata) >= $signed(pivot_q);

	always_comb begin
		unique case (state_q)
			ST_FETCH: rd_idx = i_q;
			ST_SWEEP: rd_idx = j_q[IDX_W-1:0];
			default:  rd_idx = '0;
		endcase
	end

	assign ram_raddr = {head.bank, rd_idx};

	// every sweep cycle sees the value read for j_q - 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						i_q     <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					cnt_q   <= '0;
					j_q     <= CNT_W'(1);
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (ge) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (j_q == n_cnt) begin
						state_q <= ST_EMIT;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LATCH) begin
			pivot_q <= ram_rdata;
		end
	end

	// output register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_position <= POS_W'(i_q);
			ge_count      <= GE_W'(cnt_q);
			overflowed    <= head.ovf;
			final_result  <= is_last;
		end
	end

endmodule

@@ sv/tie_aware_greater_equal_count.sv @@
// Loads a set of signed Q16.16 statistics, one per transfer, the last one
// flagged by is_final, then returns one result per stored value in load order
// with the number of stored values greater than or equal to it (ties share the
// largest position). Values past MAX_ITEMS are dropped and the whole set then
// reports overflowed. A single read port of the value store is swept once per
// result. The store has two banks and a two-entry job queue, so the next set
// loads while the previous one is being ranked; input stalls only when both
// banks hold sets not yet fully ranked.
module tie_aware_greater_equal_count #(
	parameter int MAX_ITEMS  = tawc_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = tawc_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tawc_pkg::STAT_W-1:0] stat_value,
	input  logic                               is_final,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tawc_pkg::POS_W-1:0]         item_position,
	output logic [tawc_pkg::GE_W-1:0]          ge_count,
	output logic                               overflowed,
	output logic                               final_result
);

	import tawc_pkg::*;

	localparam int ADDR_W = $clog2(MAX_ITEMS) + 1;

	logic                  job_full;
	logic                  job_push;
	job_t                  job_data;
	logic                  job_pop;
	logic                  head_valid;
	job_t                  head;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;

	tawc_front #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.stat_value (stat_value),
		.is_final   (is_final),
		.job_full   (job_full),
		.job_push   (job_push),
		.job_data   (job_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	tawc_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (2 ** ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tawc_job_fifo u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_data  (job_data),
		.full       (job_full),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tawc_back #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (job_pop),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_position (item_position),
		.ge_count      (ge_count),
		.overflowed    (overflowed),
		.final_result  (final_result)
	);

endmodule

@@ sv/tawc_chk.sv @@
module tawc_chk #(
	parameter int MAX_ITEMS = tawc_pkg::MAX_ITEMS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [tawc_pkg::POS_W-1:0]         item_position,
	input logic [tawc_pkg::GE_W-1:0]          ge_count,
	input logic                               overflowed,
	input logic                               final_result
);

	import tawc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(item_position) && $stable(ge_count)
			&& $stable(overflowed) && $stable(final_result))
		else $error("result changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ge_count != '0 && ge_count <= GE_W'(MAX_ITEMS)
			&& GE_W'(item_position) < GE_W'(MAX_ITEMS))
		else $error("result out of range");

	// on the last result the set size is position + 1
	a_final_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_result |-> ge_count <= GE_W'(item_position) + GE_W'(1))
		else $error("count exceeds set size");

endmodule

bind tie_aware_greater_equal_count tawc_chk #(.MAX_ITEMS(MAX_ITEMS)) u_chk (.*);

@@ tb/ge_rank_checker.sv @@
module ge_rank_checker
	import tawc_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [STAT_W-1:0]  stat_value,
	input  logic                      is_final,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [POS_W-1:0]          item_position,
	input  logic [GE_W-1:0]           ge_count,
	input  logic                      overflowed,
	input  logic                      final_result,
	output int                        mismatches,
	output int                        ranks_pending,
	output int                        ranks_seen
);

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [GE_W-1:0]  count;
		logic             ovf;
		logic             last;
	} rank_t;

	logic signed [63:0] loaded [MAX_ITEMS];
	int                 loaded_n;
	logic               dropped;
	rank_t              expected_ranks [$];
	rank_t              want;

	// keep the low VALUE_BITS bits of the sign-extended statistic, as signed
	function automatic logic signed [63:0] narrow(input logic signed [STAT_W-1:0] v);
		logic signed [63:0] wide;
		wide = v;
		wide = wide <<< (64 - VALUE_BITS);
		return wide >>> (64 - VALUE_BITS);
	endfunction

	// one expected result per loaded value, in load order
	task automatic rank_set();
		int count;
		for (int i = 0; i < loaded_n; i++) begin
			count = 0;
			for (int j = 0; j < loaded_n; j++)
				if (loaded[j] >= loaded[i])
					count++;
			expected_ranks.push_back('{pos: POS_W'(i), count: GE_W'(count),
				ovf: dropped, last: (i == loaded_n - 1)});
		end
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_n = 0;
			dropped  = 1'b0;
			expected_ranks.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (loaded_n < MAX_ITEMS) begin
					loaded[loaded_n] = narrow(stat_value);
					loaded_n++;
				end else begin
					dropped = 1'b1;
				end
				// a dropped final item still closes the set
				if (is_final) begin
					rank_set();
					loaded_n = 0;
					dropped  = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				ranks_seen++;
				if (expected_ranks.size() == 0) begin
					$error("unexpected result transfer at position %0d", item_position);
					mismatches++;
				end else begin
					want = expected_ranks.pop_front();
					check_field("item_position", want.pos, item_position);
					check_field("ge_count", want.count, ge_count);
					check_field("overflowed", want.ovf, overflowed);
					check_field("final_result", want.last, final_result);
				end
			end
		end
		ranks_pending = expected_ranks.size();
	end

endmodule

@@ tb/tb.sv @@
module tb;
	import tawc_pkg::*;

	localparam logic signed [STAT_W-1:0] STAT_MIN = {1'b1, {(STAT_W-1){1'b0}}};
	localparam logic signed [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};
	localparam logic signed [STAT_W-1:0] ONE      = STAT_W'(1) << 16;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic signed [STAT_W-1:0] stat_value = '0;
	logic                     is_final   = 1'b0;
	logic                     out_ready  = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic [POS_W-1:0]         item_position;
	logic [GE_W-1:0]          ge_count;
	logic                     overflowed;
	logic                     final_result;

	int mismatches;
	int ranks_pending;
	int ranks_seen;
	int idle_pct      = 0;
	int stall_pct     = 0;
	int items_sent    = 0;
	int sets_sent     = 0;
	int overflow_sets = 0;

	logic signed [STAT_W-1:0] tie_pool [4];

	tie_aware_greater_equal_count uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stat_value    (stat_value),
		.is_final      (is_final),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_position (item_position),
		.ge_count      (ge_count),
		.overflowed    (overflowed),
		.final_result  (final_result)
	);

	ge_rank_checker rank_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stat_value    (stat_value),
		.is_final      (is_final),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.item_position (item_position),
		.ge_count      (ge_count),
		.overflowed    (overflowed),
		.final_result  (final_result),
		.mismatches    (mismatches),
		.ranks_pending (ranks_pending),
		.ranks_seen    (ranks_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		#3_000_000;
		$display("tie_aware_greater_equal_count regression: fail");
		$finish;
	end

	task automatic set_phase(input int phase);
		case (phase)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 55; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 55; end
			default: begin idle_pct = 17; stall_pct = 17; end
		endcase
	endtask

	task automatic send_stat(input logic signed [STAT_W-1:0] v, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		stat_value <= v;
		is_final   <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// mix of full-range values, ties from a per-set pool, extremes and small integers
	function automatic logic signed [STAT_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return tie_pool[$urandom_range(0, 3)];
			7: case ($urandom_range(0, 3))
				0: return STAT_MIN;
				1: return STAT_MAX;
				2: return '0;
				default: return '1;
			endcase
			default: return (STAT_W'($urandom_range(0, 15)) - STAT_W'(8)) << 16;
		endcase
	endfunction

	task automatic send_random_set(input int n);
		foreach (tie_pool[k])
			tie_pool[k] = $urandom;
		for (int k = 0; k < n; k++)
			send_stat(pick_value(), k == n - 1);
		sets_sent++;
		if (n > MAX_ITEMS_DEF)
			overflow_sets++;
	endtask

	task automatic send_list(input logic signed [STAT_W-1:0] vals [$]);
		foreach (vals[k])
			send_stat(vals[k], k == vals.size() - 1);
		sets_sent++;
	endtask

	initial begin
		int set_n;
		int size;
		int r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_phase(0);
		send_list('{STAT_MIN});
		send_list('{STAT_MAX, STAT_MIN, '0, '1, STAT_W'(1)});
		send_list('{ONE + (ONE >>> 1), ONE + (ONE >>> 1), ONE + (ONE >>> 1),
			ONE + (ONE >>> 1)});
		send_list('{2 * ONE, -2 * ONE, 2 * ONE, '0, -2 * ONE, 2 * ONE, STAT_MAX, STAT_MAX});
		send_list('{STAT_W'(32'h5555_5555), STAT_W'(32'haaaa_aaaa),
			STAT_W'(32'h7fff_0000), STAT_W'(32'h8000_ffff)});

		// full store, final item dropped, several dropped, interleaved with random sizes
		set_n = 0;
		while (items_sent < 520) begin
			set_phase((set_n / 3) % 4);
			r = $urandom_range(0, 19);
			if (set_n == 0)
				size = MAX_ITEMS_DEF;
			else if (set_n == 4)
				size = MAX_ITEMS_DEF + 1;
			else if (set_n == 8)
				size = MAX_ITEMS_DEF + 6;
			else if (r == 0)
				size = MAX_ITEMS_DEF;
			else if (r == 1)
				size = $urandom_range(MAX_ITEMS_DEF + 1, MAX_ITEMS_DEF + 8);
			else
				size = $urandom_range(1, 12);
			send_random_set(size);
			set_n++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (ranks_pending != 0)
			@(posedge clk);
		// quiet window: anything arriving now is unexpected
		repeat (200) @(posedge clk);

		$display("%0d statistics in %0d sets (%0d overflowed), %0d rank results checked",
			items_sent, sets_sent, overflow_sets, ranks_seen);
		$display("idle phases: none, sender 55%%, receiver 55%%, both 17%%");
		if (mismatches == 0)
			$display("tie_aware_greater_equal_count regression: pass");
		else
			$display("tie_aware_greater_equal_count regression: fail");
		$finish;
	end

endmodule
